>>> sv/bqdf1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdf1_pkg
// Shared types and constants for the Direct Form I biquad lowpass core:
// coefficient format, register map, request kinds, default parameters.
// ----------------------------------------------------------------------------
package bqdf1_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 22;

    // Coefficients are signed Q2.22 words
    localparam int COEF_W = 24;

    // Configuration port geometry
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // Request kinds; code 3 is unused and ignored
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PRELOAD = 2'd2;

    // Coefficient set handed from the register file to the datapath
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

endpackage

>>> sv/bqdf1_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdf1_apb_regs
// APB-style register file holding the five filter coefficients.
// Writes land on the access phase; reads return the sign-extended value.
// ----------------------------------------------------------------------------
module bqdf1_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bqdf1_pkg::APB_AW-1:0]    paddr,
    input  logic [bqdf1_pkg::APB_DW-1:0]    pwdata,
    output logic [bqdf1_pkg::APB_DW-1:0]    prdata,
    output logic                            pready,
    output bqdf1_pkg::t_coefs               o_coefs
);

    bqdf1_pkg::t_coefs                   r_coefs;
    logic [bqdf1_pkg::REG_IDX_W-1:0]     w_idx;
    logic                                w_wr;
    logic signed [bqdf1_pkg::COEF_W-1:0] w_wcoef;
    logic signed [bqdf1_pkg::COEF_W-1:0] w_rcoef;
    logic                                w_rhit;

    assign pready  = 1'b1;
    assign w_idx   = paddr[bqdf1_pkg::APB_AW-1:2];
    assign w_wr    = psel && penable && pwrite && pready;
    assign w_wcoef = pwdata[bqdf1_pkg::COEF_W-1:0];

    // Coefficient registers; unmapped indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                bqdf1_pkg::REG_B0: r_coefs.b0 <= w_wcoef;
                bqdf1_pkg::REG_B1: r_coefs.b1 <= w_wcoef;
                bqdf1_pkg::REG_B2: r_coefs.b2 <= w_wcoef;
                bqdf1_pkg::REG_A1: r_coefs.a1 <= w_wcoef;
                bqdf1_pkg::REG_A2: r_coefs.a2 <= w_wcoef;
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        w_rcoef = '0;
        w_rhit  = 1'b1;
        unique case (w_idx)
            bqdf1_pkg::REG_B0: w_rcoef = r_coefs.b0;
            bqdf1_pkg::REG_B1: w_rcoef = r_coefs.b1;
            bqdf1_pkg::REG_B2: w_rcoef = r_coefs.b2;
            bqdf1_pkg::REG_A1: w_rcoef = r_coefs.a1;
            bqdf1_pkg::REG_A2: w_rcoef = r_coefs.a2;
            default:           w_rhit  = 1'b0;
        endcase
    end

    assign prdata  = w_rhit ? bqdf1_pkg::APB_DW'(w_rcoef) : '0;
    assign o_coefs = r_coefs;

endmodule

>>> sv/bqdf1_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqdf1_mac
// Biquad arithmetic: five parallel products, exact sum, round half up,
// shift down by the coefficient fraction bits and saturate to the sample range.
// ----------------------------------------------------------------------------
module bqdf1_mac #(
    parameter int SAMPLE_BITS    = bqdf1_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqdf1_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_x1,
    input  logic signed [SAMPLE_BITS-1:0] i_x2,
    input  logic signed [SAMPLE_BITS-1:0] i_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_y2,
    input  bqdf1_pkg::t_coefs             i_coefs,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_clip
);

    localparam int PROD_W = SAMPLE_BITS + bqdf1_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF =
        {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] w_pb0, w_pb1, w_pb2, w_pa1, w_pa2;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_shr;

    // Products, all in parallel
    assign w_pb0 = i_x  * i_coefs.b0;
    assign w_pb1 = i_x1 * i_coefs.b1;
    assign w_pb2 = i_x2 * i_coefs.b2;
    assign w_pa1 = i_y1 * i_coefs.a1;
    assign w_pa2 = i_y2 * i_coefs.a2;

    // Exact sum plus rounding offset, then floor shift
    assign w_acc = ACC_W'(w_pb0) + ACC_W'(w_pb1) + ACC_W'(w_pb2)
                 - ACC_W'(w_pa1) - ACC_W'(w_pa2) + RND_HALF;
    assign w_shr = w_acc >>> COEF_FRAC_BITS;

    // Saturation
    always_comb begin
        priority if (w_shr > SAT_HI) begin
            o_y    = SAT_HI[SAMPLE_BITS-1:0];
            o_clip = 1'b1;
        end else if (w_shr < SAT_LO) begin
            o_y    = SAT_LO[SAMPLE_BITS-1:0];
            o_clip = 1'b1;
        end else begin
            o_y    = w_shr[SAMPLE_BITS-1:0];
            o_clip = 1'b0;
        end
    end

endmodule

>>> sv/biquad_lowpass_df1_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_lowpass_df1_core
// Second-order IIR lowpass in Direct Form I with programmable Q2.22
// coefficients, rounded and saturated output, and history preload/reset.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_req_type, i_sample_value
//  result    out        o_valid / i_stall    o_filtered, o_clipped
//  config    in         psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  One transaction per cycle while the result channel is not stalled; a sample
//  result is presented after its input transaction passes the input register,
//  then the result register. The whole filter sum is evaluated between the input
//  register and the result register, so the feedback path closes combinationally.
//  Synchronous active-low reset clears coefficients and the delay line.
//  A stalled result holds in the result register while the next transaction
//  still enters; history and preload requests never need the result slot.
// ----------------------------------------------------------------------------
module biquad_lowpass_df1_core #(
    parameter int SAMPLE_BITS    = bqdf1_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = bqdf1_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bqdf1_pkg::REQ_W-1:0]     i_req_type,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample_value,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [SAMPLE_BITS-1:0]   o_filtered,
    output logic                            o_clipped,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bqdf1_pkg::APB_AW-1:0]    paddr,
    input  logic [bqdf1_pkg::APB_DW-1:0]    pwdata,
    output logic [bqdf1_pkg::APB_DW-1:0]    prdata,
    output logic                            pready
);

    bqdf1_pkg::t_coefs               w_coefs;

    logic                            r_in_valid;
    logic [bqdf1_pkg::REQ_W-1:0]     r_in_kind;
    logic signed [SAMPLE_BITS-1:0]   r_in_x;

    logic signed [SAMPLE_BITS-1:0]   r_past_in_1, r_past_in_2;
    logic signed [SAMPLE_BITS-1:0]   r_past_out_1, r_past_out_2;

    logic                            r_out_valid;
    logic signed [SAMPLE_BITS-1:0]   r_out_y;
    logic                            r_out_clip;

    logic signed [SAMPLE_BITS-1:0]   w_y;
    logic                            w_clip;
    logic                            w_is_sample;
    logic                            w_fire;
    logic                            w_in_take;

    // Coefficient registers
    bqdf1_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    // Filter arithmetic
    bqdf1_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_x     (r_in_x),
        .i_x1    (r_past_in_1),
        .i_x2    (r_past_in_2),
        .i_y1    (r_past_out_1),
        .i_y2    (r_past_out_2),
        .i_coefs (w_coefs),
        .o_y     (w_y),
        .o_clip  (w_clip)
    );

    // Handshake: a sample needs a free (or draining) result slot
    assign w_is_sample = (r_in_kind == bqdf1_pkg::REQ_SAMPLE);
    assign w_fire      = r_in_valid && (!w_is_sample || !(r_out_valid && i_stall));
    assign o_stall     = r_in_valid && !w_fire;
    assign w_in_take   = i_valid && !o_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_kind <= i_req_type;
            r_in_x    <= i_sample_value;
        end
    end

    // Delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_past_in_1  <= '0;
            r_past_in_2  <= '0;
            r_past_out_1 <= '0;
            r_past_out_2 <= '0;
        end else if (w_fire) begin
            unique case (r_in_kind)
                bqdf1_pkg::REQ_SAMPLE: begin
                    r_past_in_2  <= r_past_in_1;
                    r_past_in_1  <= r_in_x;
                    r_past_out_2 <= r_past_out_1;
                    r_past_out_1 <= w_y;
                end
                bqdf1_pkg::REQ_RESET: begin
                    r_past_in_2  <= r_past_in_1;
                    r_past_out_1 <= r_past_in_1;
                    r_past_out_2 <= r_past_in_1;
                end
                bqdf1_pkg::REQ_PRELOAD: begin
                    r_past_in_1  <= r_in_x;
                    r_past_in_2  <= r_in_x;
                    r_past_out_1 <= r_in_x;
                    r_past_out_2 <= r_in_x;
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_sample) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_sample) begin
            r_out_y    <= w_y;
            r_out_clip <= w_clip;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_y;
    assign o_clipped  = r_out_clip;

    // Checks
    a_clip_at_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            ((&o_filtered[SAMPLE_BITS-2:0]) && !o_filtered[SAMPLE_BITS-1]) ||
            (!(|o_filtered[SAMPLE_BITS-2:0]) && o_filtered[SAMPLE_BITS-1]))
        else $error("clipped result is not at a saturation rail");

    a_feedback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_is_sample |=> o_valid && (r_past_out_1 == o_filtered))
        else $error("newest past output differs from the delivered result");

    a_preload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && (r_in_kind == bqdf1_pkg::REQ_PRELOAD) |=>
            (r_past_in_1 == r_past_in_2) && (r_past_in_1 == r_past_out_1) &&
            (r_past_in_1 == r_past_out_2))
        else $error("preload left the delay line inconsistent");

    a_no_result_for_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !w_is_sample && !o_valid |=> !o_valid)
        else $error("history request produced a result");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Direct Form I biquad core. A queue-fed driver
// offers filter, preload and history-reset requests with random gaps; a
// monitor stalls at random and checks every result against a bit-exact
// fixed-point filter model kept in the bench. Coefficients go in over APB
// between phases and are read back.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SB = bqdf1_pkg::SAMPLE_BITS_DEF;
    localparam int FB = bqdf1_pkg::COEF_FRAC_BITS_DEF;
    localparam int CW = bqdf1_pkg::COEF_W;
    localparam int IW = bqdf1_pkg::REG_IDX_W;
    localparam int KW = bqdf1_pkg::REQ_W;
    localparam int DW = bqdf1_pkg::APB_DW;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 225;

    localparam logic [KW-1:0] REQ_UNUSED   = 2'd3;
    localparam logic [IW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IW-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [SB-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SB-1:0] SAMPLE_MIN = 16'sh8000;

    typedef struct {
        logic [KW-1:0]        kind;
        logic signed [SB-1:0] value;
    } t_filt_req;

    typedef struct {
        logic signed [SB-1:0] filtered;
        logic                 clipped;
    } t_filt_out;

    // DUT signals; the inputs are known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [KW-1:0]          i_req_type = '0;
    logic signed [SB-1:0]   i_sample_value = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic signed [SB-1:0]   o_filtered;
    logic                   o_clipped;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [bqdf1_pkg::APB_AW-1:0] paddr = '0;
    logic [DW-1:0]          pwdata = '0;
    logic [DW-1:0]          prdata;
    logic                   pready;

    // Filter model state
    logic signed [CW-1:0] coef_q [0:4];
    logic signed [SB-1:0] hist_x1 = '0, hist_x2 = '0, hist_y1 = '0, hist_y2 = '0;

    t_filt_req req_queue [$];
    t_filt_out expected_out [$];

    bit gaps_on = 1'b0;
    int src_gap = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;
    int results_seen = 0;
    int fail_count = 0;
    int cycle_count = 0;

    biquad_lowpass_df1_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_filtered     (o_filtered),
        .o_clipped      (o_clipped),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Fixed-point DF1 step: exact sum, round half up, saturate
    function automatic void filter_predict(input logic [KW-1:0] kind,
                                           input logic signed [SB-1:0] x);
        longint acc;
        longint y;
        logic   clip;
        t_filt_out res;
        case (kind)
            bqdf1_pkg::REQ_RESET: begin
                hist_y1 = hist_x1;
                hist_y2 = hist_x1;
                hist_x2 = hist_x1;
            end
            bqdf1_pkg::REQ_PRELOAD: begin
                hist_x1 = x;
                hist_x2 = x;
                hist_y1 = x;
                hist_y2 = x;
            end
            bqdf1_pkg::REQ_SAMPLE: begin
                acc = longint'(coef_q[bqdf1_pkg::REG_B0]) * longint'(x)
                    + longint'(coef_q[bqdf1_pkg::REG_B1]) * longint'(hist_x1)
                    + longint'(coef_q[bqdf1_pkg::REG_B2]) * longint'(hist_x2)
                    - longint'(coef_q[bqdf1_pkg::REG_A1]) * longint'(hist_y1)
                    - longint'(coef_q[bqdf1_pkg::REG_A2]) * longint'(hist_y2);
                acc += longint'(1) << (FB - 1);
                y = acc >>> FB;
                clip = 1'b0;
                if (y > longint'(SAMPLE_MAX)) begin
                    y = SAMPLE_MAX;
                    clip = 1'b1;
                end else if (y < longint'(SAMPLE_MIN)) begin
                    y = SAMPLE_MIN;
                    clip = 1'b1;
                end
                hist_x2 = hist_x1;
                hist_x1 = x;
                hist_y2 = hist_y1;
                hist_y1 = y[SB-1:0];
                res.filtered = y[SB-1:0];
                res.clipped = clip;
                expected_out.push_back(res);
            end
            default: ;  // unused kind: no effect
        endcase
    endfunction

    // Request driver: one transaction per free slot, random gaps after some
    always @(posedge i_clk) begin : req_driver
        t_filt_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (i_valid && !o_stall)
                filter_predict(i_req_type, i_sample_value);
            if (!i_valid || !o_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    nxt = req_queue.pop_front();
                    i_valid <= 1'b1;
                    i_req_type <= nxt.kind;
                    i_sample_value <= nxt.value;
                    if (gaps_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 3);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare, then pick next stall
    always @(posedge i_clk) begin : result_monitor
        t_filt_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_out.size() == 0) begin
                    $error("unexpected result: filtered=%0d clipped=%0b",
                           o_filtered, o_clipped);
                    fail_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (o_filtered !== want.filtered) begin
                        $error("filtered: expected %0d, actual %0d",
                               want.filtered, o_filtered);
                        fail_count++;
                    end
                    if (o_clipped !== want.clipped) begin
                        $error("clipped: expected %0b, actual %0b",
                               want.clipped, o_clipped);
                        fail_count++;
                    end
                end
            end
            // one long hold so the core backs up into its input
            if (!long_hold_done && results_seen >= 120) begin
                long_hold_done = 1'b1;
                stall_left = 48;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void queue_request(input logic [KW-1:0] kind,
                                          input logic signed [SB-1:0] value);
        t_filt_req r;
        r.kind = kind;
        r.value = value;
        req_queue.push_back(r);
    endfunction

    // Sender pause: everything accepted, every result back, pipe drained
    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_queue.size() != 0 || i_valid || expected_out.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [IW-1:0] idx,
                             input logic [DW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bqdf1_pkg::REG_B0, bqdf1_pkg::REG_B1, bqdf1_pkg::REG_B2,
            bqdf1_pkg::REG_A1, bqdf1_pkg::REG_A2: coef_q[idx] = val[CW-1:0];
            default: ;  // spare addresses are ignored
        endcase
    endtask

    task automatic cfg_check(input logic [IW-1:0] idx);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata[CW-1:0] !== coef_q[idx]) begin
            $error("coef reg %0d: expected %0d, actual %0d", idx, coef_q[idx],
                   $signed(prdata[CW-1:0]));
            fail_count++;
        end
    endtask

    // New coefficient set, written while idle and read back
    task automatic load_coefs(input logic [CW-1:0] b0, input logic [CW-1:0] b1,
                              input logic [CW-1:0] b2, input logic [CW-1:0] a1,
                              input logic [CW-1:0] a2);
        wait_idle();
        cfg_write(bqdf1_pkg::REG_B0, {{(DW-CW){b0[CW-1]}}, b0});
        cfg_write(bqdf1_pkg::REG_B1, {{(DW-CW){b1[CW-1]}}, b1});
        cfg_write(bqdf1_pkg::REG_B2, {{(DW-CW){b2[CW-1]}}, b2});
        cfg_write(bqdf1_pkg::REG_A1, {{(DW-CW){a1[CW-1]}}, a1});
        cfg_write(bqdf1_pkg::REG_A2, {{(DW-CW){a2[CW-1]}}, a2});
        for (int r = bqdf1_pkg::REG_B0; r <= bqdf1_pkg::REG_A2; r++)
            cfg_check(r[IW-1:0]);
        @(negedge i_clk);
    endtask

    // Mostly samples, some history requests and unused kinds
    task automatic queue_random(input int count);
        int pick;
        logic signed [SB-1:0] v;
        for (int n = 0; n < count; n++) begin
            pick = int'($urandom_range(0, 99));
            case ($urandom_range(0, 9))
                0: v = SAMPLE_MAX;
                1: v = SAMPLE_MIN;
                2: v = SB'(int'($urandom_range(0, 255)) - 128);
                default: v = SB'($urandom());
            endcase
            if (pick < 74)
                queue_request(bqdf1_pkg::REQ_SAMPLE, v);
            else if (pick < 84)
                queue_request(bqdf1_pkg::REQ_PRELOAD, v);
            else if (pick < 93)
                queue_request(bqdf1_pkg::REQ_RESET, v);
            else
                queue_request(REQ_UNUSED, v);
        end
    endtask

    function automatic logic [CW-1:0] small_coef();
        return CW'(int'($urandom_range(0, 4194303)) - 2097152);
    endfunction

    initial begin
        for (int r = 0; r <= 4; r++)
            coef_q[r] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        gaps_on = 1'b1;

        // coefficients come out of reset at zero
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MAX);
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MIN);

        // 0.5, 0.25, 0.125, -0.5, 0.25: history visible in every output
        load_coefs(24'sd2097152, 24'sd1048576, 24'sd524288, -24'sd2097152, 24'sd1048576);
        // spare addresses must not disturb the coefficients
        cfg_write(REG_SPARE_LO, 32'h007f_ffff);
        cfg_write(REG_SPARE_HI, 32'hff80_0000);
        @(negedge i_clk);
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MAX);
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MIN);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'sd0);
        queue_request(bqdf1_pkg::REQ_SAMPLE, -16'sd1);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'sd1);
        queue_request(bqdf1_pkg::REQ_PRELOAD, SAMPLE_MAX);
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MAX);     // positive saturation
        queue_request(bqdf1_pkg::REQ_PRELOAD, SAMPLE_MIN);
        queue_request(bqdf1_pkg::REQ_SAMPLE, SAMPLE_MIN);     // negative saturation
        queue_request(bqdf1_pkg::REQ_RESET, 16'sd1234);       // history from last input
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'sd0);
        queue_request(REQ_UNUSED, 16'sd777);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'sd100);
        queue_request(bqdf1_pkg::REQ_PRELOAD, 16'sd0);
        queue_request(bqdf1_pkg::REQ_RESET, -16'sd1);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'sd5);         // rounding at exact half
        queue_request(bqdf1_pkg::REQ_SAMPLE, -16'sd5);
        queue_request(REQ_UNUSED, SAMPLE_MIN);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'h5555);
        queue_request(bqdf1_pkg::REQ_SAMPLE, 16'haaaa);

        // coefficient extremes, both polarities per register
        load_coefs(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff);
        queue_random(PHASE_ITEMS);
        load_coefs(24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000);
        queue_random(PHASE_ITEMS);

        // Butterworth lowpass at fc = fs/10
        load_coefs(24'sd282929, 24'sd565858, 24'sd282929, -24'sd4794017, 24'sd1731409);
        queue_random(PHASE_ITEMS);

        load_coefs(CW'($urandom()), CW'($urandom()), CW'($urandom()),
                   CW'($urandom()), CW'($urandom()));
        queue_random(PHASE_ITEMS);

        // closing stretch without any idling
        wait_idle();
        gaps_on = 1'b0;
        load_coefs(small_coef(), small_coef(), small_coef(), small_coef(), small_coef());
        queue_random(PHASE_ITEMS);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (expected_out.size() != 0) begin
            $error("%0d results never arrived", expected_out.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
